// File: src/wft_pkg.sv
package wft_pkg;

  localparam int unsigned TableDepth = 1024;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned UsedW      = IdxW + 1;
  localparam int unsigned TopMax     = 16;
  localparam int unsigned KeyW       = 64;
  localparam int unsigned CntW       = 20;
  localparam int unsigned TopW       = 5;

  localparam logic [TopW-1:0] TopCountReset = TopW'(10);
  localparam logic [CntW-1:0] CountMax      = {CntW{1'b1}};

  typedef enum logic [2:0] {
    StExisting = 3'd0,
    StAdded    = 3'd1,
    StDropped  = 3'd2,
    StTop      = 3'd3,
    StEmpty    = 3'd4
  } status_e;

  typedef enum logic {
    OpCount  = 1'b0,
    OpReport = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    SIdle,
    SScan,
    SWrite,
    SRScan,
    SRKey,
    SOut
  } state_e;

endpackage

// File: src/wft_in_if.sv
interface wft_in_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [wft_pkg::KeyW-1:0]   key;

  modport source (output valid, op, key, input ready);
  modport sink   (input valid, op, key, output ready);
endinterface

// File: src/wft_out_if.sv
interface wft_out_if;
  logic                       valid;
  logic                       ready;
  logic [2:0]                 status;
  logic [wft_pkg::KeyW-1:0]   word_key;
  logic [wft_pkg::CntW-1:0]   occurrences;
  logic                       last;

  modport source (output valid, status, word_key, occurrences, last, input ready);
  modport sink   (input valid, status, word_key, occurrences, last, output ready);
endinterface

// File: src/word_frequency_top_k.sv
// Word frequency table with top-k report.
// Channels: in_if carries words (op, key); out_if carries result words
// (status, word_key, occurrences, last); cfg_we_i/cfg_wdata_i write top_count.
// A count word scans the used entries one memory read per cycle, then writes
// the new or incremented entry.
// The key and count memories share one read address and are read together.
// A report word runs one full scan of the used entries for every entry it
// emits.
// Each result sits in an output register. The block goes on working while
// the register is full and waits only when its next result is ready, so a
// stalled receiver holds the block at that point.
// Reset empties the table (entries_used to zero) and sets top_count to 10;
// no clearing pass is needed since only used entries are ever read.
// A new word is accepted only once the previous one has finished.
module word_frequency_top_k (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [wft_pkg::TopW-1:0] cfg_wdata_i,
  wft_in_if.sink                   in_if,
  wft_out_if.source                out_if
);

  localparam int unsigned IdxW  = wft_pkg::IdxW;
  localparam int unsigned UsedW = wft_pkg::UsedW;
  localparam int unsigned KeyW  = wft_pkg::KeyW;
  localparam int unsigned CntW  = wft_pkg::CntW;

  // memories
  logic [KeyW-1:0] key_mem [wft_pkg::TableDepth];
  logic [CntW-1:0] cnt_mem [wft_pkg::TableDepth];
  logic [KeyW-1:0] rd_key;
  logic [CntW-1:0] rd_cnt;
  logic [IdxW-1:0] rd_addr, wr_addr;
  logic            wr_en;
  logic [KeyW-1:0] wr_key;
  logic [CntW-1:0] wr_cnt;

  wft_pkg::state_e state_q, state_d;
  logic [UsedW-1:0] used_q, used_d;
  logic [wft_pkg::TopW-1:0] top_q;
  logic [KeyW-1:0] key_q, key_d;
  logic [UsedW-1:0] idx_q, idx_d;      // address issued
  logic [UsedW-1:0] ridx_q, ridx_d;    // address whose data is on rd_*
  logic             rv_q, rv_d;        // read data valid
  logic             found_q, found_d;
  logic [IdxW-1:0]  best_q, best_d;
  logic [CntW-1:0]  bcnt_q, bcnt_d;
  logic [IdxW-1:0]  pidx_q, pidx_d;
  logic [CntW-1:0]  pcnt_q, pcnt_d;
  logic [4:0]       n_q, n_d;
  logic [4:0]       lim_q, lim_d;
  logic             ov_q, ov_d;
  logic [2:0]       ost_q, ost_d;
  logic [KeyW-1:0]  okey_q, okey_d;
  logic [CntW-1:0]  ocnt_q, ocnt_d;
  logic             olast_q, olast_d;
  logic             ret_scan_q, ret_scan_d; // after output, rescan

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      cnt_mem[wr_addr] <= wr_cnt;
    end
    rd_key <= key_mem[rd_addr];
    rd_cnt <= cnt_mem[rd_addr];
  end

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= wft_pkg::TopCountReset;
    end else if (cfg_we_i) begin
      top_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= wft_pkg::SIdle;
      used_q     <= '0;
      ov_q       <= 1'b0;
      rv_q       <= 1'b0;
      ret_scan_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      used_q     <= used_d;
      ov_q       <= ov_d;
      rv_q       <= rv_d;
      ret_scan_q <= ret_scan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    idx_q   <= idx_d;
    ridx_q  <= ridx_d;
    found_q <= found_d;
    best_q  <= best_d;
    bcnt_q  <= bcnt_d;
    pidx_q  <= pidx_d;
    pcnt_q  <= pcnt_d;
    n_q     <= n_d;
    lim_q   <= lim_d;
    ost_q   <= ost_d;
    okey_q  <= okey_d;
    ocnt_q  <= ocnt_d;
    olast_q <= olast_d;
  end

  logic [4:0] lim_c;
  logic       cand;

  always_comb begin
    state_d    = state_q;
    used_d     = used_q;
    key_d      = key_q;
    idx_d      = idx_q;
    ridx_d     = ridx_q;
    rv_d       = 1'b0;
    found_d    = found_q;
    best_d     = best_q;
    bcnt_d     = bcnt_q;
    pidx_d     = pidx_q;
    pcnt_d     = pcnt_q;
    n_d        = n_q;
    lim_d      = lim_q;
    ov_d       = ov_q;
    ost_d      = ost_q;
    okey_d     = okey_q;
    ocnt_d     = ocnt_q;
    olast_d    = olast_q;
    ret_scan_d = ret_scan_q;
    rd_addr    = idx_q[IdxW-1:0];
    wr_en      = 1'b0;
    wr_addr    = used_q[IdxW-1:0];
    wr_key     = key_q;
    wr_cnt     = CntW'(1);
    in_if.ready = 1'b0;
    lim_c      = '0;
    cand       = 1'b0;

    // clamp the report limit
    if (top_q == '0) lim_c = 5'd1;
    else if (top_q > 5'(wft_pkg::TopMax)) lim_c = 5'(wft_pkg::TopMax);
    else lim_c = top_q;
    if (UsedW'(lim_c) > used_q) lim_c = used_q[4:0];

    if (ov_q && out_if.ready) ov_d = 1'b0;

    case (state_q)
      wft_pkg::SIdle: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          key_d   = in_if.key;
          idx_d   = '0;
          found_d = 1'b0;
          n_d     = '0;
          lim_d   = lim_c;
          if (in_if.op == wft_pkg::OpCount) begin
            state_d = wft_pkg::SScan;
          end else if (used_q == '0) begin
            ost_d = wft_pkg::StEmpty; okey_d = '0; ocnt_d = '0; olast_d = 1'b1;
            ret_scan_d = 1'b0;
            state_d = wft_pkg::SOut;
          end else begin
            state_d = wft_pkg::SRScan;
          end
        end
      end
      // scan for the key: issue address, compare returned data
      wft_pkg::SScan: begin
        if (rv_q && rd_key == key_q) begin
          found_d = 1'b1;
          best_d  = ridx_q[IdxW-1:0];
          bcnt_d  = (rd_cnt == wft_pkg::CountMax) ? rd_cnt : rd_cnt + CntW'(1);
          state_d = wft_pkg::SWrite;
        end else if (idx_q < used_q) begin
          rd_addr = idx_q[IdxW-1:0];
          ridx_d  = idx_q;
          rv_d    = 1'b1;
          idx_d   = idx_q + UsedW'(1);
        end else if (!rv_q) begin
          state_d = wft_pkg::SWrite;
        end
      end
      wft_pkg::SWrite: begin
        ret_scan_d = 1'b0;
        olast_d    = 1'b1;
        okey_d     = key_q;
        if (found_q) begin
          wr_en = 1'b1; wr_addr = best_q; wr_cnt = bcnt_q;
          ost_d = wft_pkg::StExisting; ocnt_d = bcnt_q;
        end else if (used_q >= UsedW'(wft_pkg::TableDepth)) begin
          ost_d = wft_pkg::StDropped; ocnt_d = '0;
        end else begin
          wr_en = 1'b1;
          ost_d = wft_pkg::StAdded; ocnt_d = CntW'(1);
          used_d = used_q + UsedW'(1);
        end
        state_d = wft_pkg::SOut;
      end
      // report pass: find the best remaining candidate
      wft_pkg::SRScan: begin
        if (rv_q) begin
          cand = (n_q == '0) || (rd_cnt < pcnt_q) ||
                 (rd_cnt == pcnt_q && ridx_q[IdxW-1:0] > pidx_q);
          if (cand && (!found_q || rd_cnt > bcnt_q)) begin
            found_d = 1'b1;
            best_d  = ridx_q[IdxW-1:0];
            bcnt_d  = rd_cnt;
          end
        end
        if (idx_q < used_q) begin
          rd_addr = idx_q[IdxW-1:0];
          ridx_d  = idx_q;
          rv_d    = 1'b1;
          idx_d   = idx_q + UsedW'(1);
        end else if (!rv_q) begin
          rd_addr = best_q;
          state_d = wft_pkg::SRKey;
        end
      end
      wft_pkg::SRKey: begin
        // memory returns the chosen key this cycle
        ost_d   = wft_pkg::StTop;
        okey_d  = rd_key;
        ocnt_d  = bcnt_q;
        olast_d = (n_q + 5'd1 == lim_q);
        pidx_d  = best_q;
        pcnt_d  = bcnt_q;
        n_d     = n_q + 5'd1;
        ret_scan_d = !(n_q + 5'd1 == lim_q);
        state_d = wft_pkg::SOut;
      end
      // hand the result to the output register, wait until free
      wft_pkg::SOut: begin
        if (!ov_q) begin
          ov_d = 1'b1;
          idx_d = '0;
          found_d = 1'b0;
          state_d = ret_scan_q ? wft_pkg::SRScan : wft_pkg::SIdle;
        end
      end
      default: state_d = wft_pkg::SIdle;
    endcase
  end

  // output register: loaded from o*_q in SOut, held until taken
  logic [2:0]      st_q;
  logic [KeyW-1:0] wk_q;
  logic [CntW-1:0] oc_q;
  logic            ls_q;
  always_ff @(posedge clk_i) begin
    if (state_q == wft_pkg::SOut && !ov_q) begin
      st_q <= ost_q;
      wk_q <= okey_q;
      oc_q <= ocnt_q;
      ls_q <= olast_q;
    end
  end

  assign out_if.valid       = ov_q;
  assign out_if.status      = st_q;
  assign out_if.word_key    = wk_q;
  assign out_if.occurrences = oc_q;
  assign out_if.last        = ls_q;

endmodule

// File: verif/tb_word_frequency_top_k.sv
`timescale 1ns / 1ps

module tb_word_frequency_top_k;

  localparam int unsigned StallLimit = 50000;
  localparam int unsigned KeyW       = wft_pkg::KeyW;
  localparam int unsigned CntW       = wft_pkg::CntW;
  localparam int unsigned TopW       = wft_pkg::TopW;

  typedef struct packed {
    wft_pkg::status_e      st;
    logic [KeyW-1:0]       key;
    logic [CntW-1:0]       occ;
    logic                  last;
  } tally_t;

  // Shadow word table; predicts results of each accepted word and checks them
  class word_tally_board;
    logic [KeyW-1:0] keys [wft_pkg::TableDepth];
    logic [CntW-1:0] cnts [wft_pkg::TableDepth];
    int unsigned     used;
    logic [TopW-1:0] top;
    tally_t          pending [$];
    int              errors;

    function new();
      used   = 0;
      top    = wft_pkg::TopCountReset;
      errors = 0;
    endfunction

    function void report_mismatch(string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      errors++;
    endfunction

    function void push(wft_pkg::status_e st, logic [KeyW-1:0] k, logic [CntW-1:0] c,
                       logic l);
      tally_t t;
      t.st   = st;
      t.key  = k;
      t.occ  = c;
      t.last = l;
      pending.push_back(t);
    endfunction

    // Predict the results of one accepted word
    function void note(wft_pkg::op_e op, logic [KeyW-1:0] k);
      int unsigned     limit, best, pidx, n, i;
      logic [CntW-1:0] pcnt;
      bit found, hit;
      if (op == wft_pkg::OpCount) begin
        hit = 0;
        for (i = 0; i < used && !hit; i++) begin
          if (keys[i] == k) begin
            if (cnts[i] != wft_pkg::CountMax) cnts[i]++;
            push(wft_pkg::StExisting, k, cnts[i], 1'b1);
            hit = 1;
          end
        end
        if (!hit) begin
          if (used >= wft_pkg::TableDepth) begin
            push(wft_pkg::StDropped, k, '0, 1'b1);
          end else begin
            keys[used] = k;
            cnts[used] = CntW'(1);
            used++;
            push(wft_pkg::StAdded, k, CntW'(1), 1'b1);
          end
        end
      end else if (used == 0) begin
        push(wft_pkg::StEmpty, '0, '0, 1'b1);
      end else begin
        limit = (top == '0) ? 1 : int'(top);
        if (limit > wft_pkg::TopMax) limit = wft_pkg::TopMax;
        if (limit > used) limit = used;
        pcnt = '0;
        pidx = 0;
        for (n = 0; n < limit; n++) begin
          found = 0;
          best  = 0;
          for (i = 0; i < used; i++) begin
            // keep only entries strictly after the previous pick
            if (n > 0 && !(cnts[i] < pcnt || (cnts[i] == pcnt && i > pidx))) continue;
            if (!found || cnts[i] > cnts[best]) begin
              best  = i;
              found = 1;
            end
          end
          pcnt = cnts[best];
          pidx = best;
          push(wft_pkg::StTop, keys[best], cnts[best], n == limit - 1);
        end
      end
    endfunction

    // Compare one accepted result word with the oldest prediction
    function void check(logic [2:0] st, logic [KeyW-1:0] k, logic [CntW-1:0] c, logic l);
      tally_t t;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result st=%0d key=%h", st, k));
        return;
      end
      t = pending.pop_front();
      if (st !== t.st)
        report_mismatch($sformatf("status %0d, want %0d", st, t.st));
      if (k !== t.key)
        report_mismatch($sformatf("word_key %h, want %h", k, t.key));
      if (c !== t.occ)
        report_mismatch($sformatf("occurrences %0d, want %0d", c, t.occ));
      if (l !== t.last)
        report_mismatch($sformatf("last %0b, want %0b", l, t.last));
    endfunction
  endclass

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [TopW-1:0] cfg_wdata_i;
  bit              no_idle;
  int              stall_cycles;
  logic [KeyW-1:0] key_pool [24];
  logic [TopW-1:0] tops [8];
  word_tally_board board;

  wft_in_if  word_in ();
  wft_out_if word_out ();

  word_frequency_top_k i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (word_in),
    .out_if      (word_out)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Randomly stall the result side
  always @(negedge clk_i) begin
    word_out.ready <= no_idle || ($urandom_range(99) >= 15);
  end

  // Check result words
  always @(posedge clk_i) begin
    if (rst_ni && word_out.valid && word_out.ready)
      board.check(word_out.status, word_out.word_key, word_out.occurrences, word_out.last);
  end

  // Watchdog on cycles with no accepted word
  always @(posedge clk_i) begin
    if ((word_in.valid && word_in.ready) || (word_out.valid && word_out.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles > StallLimit) begin
      $display("tb_word_frequency_top_k NOT OK");
      $finish;
    end
  end

  // Offer one word and hold it until accepted
  task automatic send(wft_pkg::op_e op, logic [KeyW-1:0] k);
    @(negedge clk_i);
    while (!no_idle && $urandom_range(99) < 15) begin
      word_in.valid <= 1'b0;
      @(negedge clk_i);
    end
    word_in.valid <= 1'b1;
    word_in.op    <= op;
    word_in.key   <= k;
    do @(posedge clk_i); while (!word_in.ready);
    board.note(op, k);
  endtask

  // Drop valid and wait for every predicted result, then let the block settle
  task automatic drain();
    @(negedge clk_i);
    word_in.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_top(logic [TopW-1:0] v);
    drain();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    board.top = v;
  endtask

  function automatic logic [KeyW-1:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    int r;
    tops           = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd5, 5'd10, 5'd2, 5'd17};
    board          = new();
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    no_idle        = 1'b0;
    stall_cycles   = 0;
    word_in.valid  = 1'b0;
    word_in.op     = wft_pkg::OpCount;
    word_in.key    = '0;
    word_out.ready = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty report, extreme keys, repeats and ties
    send(wft_pkg::OpReport, rand_key());
    send(wft_pkg::OpCount, '0);
    send(wft_pkg::OpCount, '1);
    send(wft_pkg::OpCount, 64'h0123_4567_89ab_cdef);
    send(wft_pkg::OpCount, 64'h0123_4567_89ab_cdef);
    send(wft_pkg::OpCount, 64'hfedc_ba98_7654_3210);
    send(wft_pkg::OpCount, 64'hfedc_ba98_7654_3210);
    send(wft_pkg::OpCount, 64'h0123_4567_89ab_cdef);
    send(wft_pkg::OpReport, '0);
    write_top(TopW'(1));
    send(wft_pkg::OpReport, '1);
    write_top(TopW'(0));
    send(wft_pkg::OpReport, '0);
    write_top(TopW'(31));
    send(wft_pkg::OpReport, '0);
    write_top(TopW'(16));
    send(wft_pkg::OpCount, '1);
    send(wft_pkg::OpReport, '0);

    // Random: counts drawn mostly from a small pool so keys recur
    foreach (key_pool[i]) key_pool[i] = rand_key();
    for (int n = 0; n < 320; n++) begin
      if (n % 40 == 0) write_top(tops[(n / 40) % 8]);
      no_idle = (n >= 120 && n < 180);
      r = $urandom_range(99);
      if (r < 15)
        send(wft_pkg::OpReport, rand_key());
      else if (r < 22)
        send(wft_pkg::OpCount, rand_key());
      else
        send(wft_pkg::OpCount, key_pool[$urandom_range(23)]);
    end
    no_idle = 1'b0;

    // Mix of new keys, hits on stored keys and reports with the widest limit
    write_top(TopW'(16));
    for (int n = 0; n < 20; n++) begin
      r = $urandom_range(99);
      if (r < 30)
        send(wft_pkg::OpCount, rand_key());
      else if (r < 70)
        send(wft_pkg::OpCount, board.keys[$urandom_range(board.used - 1)]);
      else
        send(wft_pkg::OpReport, '0);
    end
    write_top(TopW'(3));
    send(wft_pkg::OpReport, '0);
    send(wft_pkg::OpCount, key_pool[0]);
    drain();

    if (board.errors == 0)
      $display("tb_word_frequency_top_k OK");
    else
      $display("tb_word_frequency_top_k NOT OK");
    $finish;
  end

endmodule
